>>> rtl/ipcf_pkg.sv
// ----------------------------------------------------------------------------
// ipcf_pkg - shared types and constants for the ISO 14443-A framer
// CRC_A polynomial, bit buffer sizing, result record type and helper
// functions for CRC_A and odd parity.
// ----------------------------------------------------------------------------
package ipcf_pkg;

    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_SEED_RST = 16'h6363;

    // 8 data bits plus one parity bit per byte on the air
    localparam int FRAME_BITS = 9;
    // Up to 7 leftover bits plus payload byte and two CRC bytes
    localparam int BUF_W      = 7 + 3 * FRAME_BITS;
    localparam int CNT_W      = $clog2(BUF_W + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] valid_bits;
        logic       frame_end;
    } t_out_item;

    // One byte of reflected CRC_A, bit by bit
    function automatic logic [15:0] crc_a_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Byte followed by its odd parity bit, LSB first
    function automatic logic [FRAME_BITS-1:0] with_parity(input logic [7:0] b);
        return {~^b, b};
    endfunction

endpackage

>>> rtl/ipcf_if.sv
// ----------------------------------------------------------------------------
// ipcf_in_if / ipcf_out_if - valid/ready channels of the framer
// Input carries payload bytes with a last flag; output carries packed bytes.
// ----------------------------------------------------------------------------
interface ipcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ipcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       frame_end;

    modport source (output valid, out_byte, valid_bits, frame_end, input ready);
    modport sink   (input valid, out_byte, valid_bits, frame_end, output ready);
endinterface

>>> rtl/iso14443a_parity_crc_framer.sv
// ----------------------------------------------------------------------------
// iso14443a_parity_crc_framer - ISO 14443-A odd parity and CRC_A framer
// Path: input register, then bit buffer into the output register, from input
//   transaction to first output byte.
// Throughput: one output byte per cycle while the output side is ready; after
//   a last byte and its CRC trailer, the next frame's first byte waits until
//   the bit buffer has drained.
// Reset: synchronous, active low; clears all handshake and frame state and
//   restores the CRC seed to 0x6363.
// ----------------------------------------------------------------------------
module iso14443a_parity_crc_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipcf_in_if.sink     i_in,
    ipcf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    // CRC seed register: loaded into the running CRC on the first byte of
    // each frame, so a write takes effect from the next frame on.
    logic [15:0] r_crc_seed;

    // Packer to output register hand-off
    logic                pop_vld;
    logic                pop_rdy;
    ipcf_pkg::t_out_item pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_seed <= ipcf_pkg::CRC_SEED_RST;
        end else if (i_cfg_we) begin
            r_crc_seed <= i_cfg_wdata;
        end
    end

    // Input register, CRC_A and bit buffer. Each payload byte becomes 9 bits
    // (data LSB first, then odd parity); on the last byte the two CRC bytes
    // follow in the same cycle, and the buffer drains one byte per cycle while
    // the output register is ready, flagging the final byte as frame end.
    ipcf_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_crc_seed (r_crc_seed),
        .i_pop_rdy  (pop_rdy),
        .o_pop_vld  (pop_vld),
        .o_item     (pop_item)
    );

    // Output register: holds one result until taken; while it waits, no byte is popped.
    ipcf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (pop_vld),
        .i_item  (pop_item),
        .o_rdy   (pop_rdy),
        .o_out   (o_out)
    );

endmodule

>>> rtl/ipcf_packer.sv
// ----------------------------------------------------------------------------
// ipcf_packer - input register, CRC_A and bit buffer
// Appends 9-bit parity-framed bytes (and the CRC trailer on the last byte)
// to a bit buffer and hands out one output byte per cycle while i_pop_rdy holds.
// ----------------------------------------------------------------------------
module ipcf_packer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipcf_in_if.sink              i_in,
    input  logic [15:0]          i_crc_seed,
    input  logic                 i_pop_rdy,
    output logic                 o_pop_vld,
    output ipcf_pkg::t_out_item  o_item
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // frame state and bit buffer
    logic                        r_in_frame;
    logic [15:0]                 r_crc;
    logic [ipcf_pkg::BUF_W-1:0]  r_buf;
    logic [ipcf_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_end;

    logic                        w_full;
    logic                        w_pop;
    logic                        w_take;
    logic [ipcf_pkg::BUF_W-1:0]  w_buf_a;
    logic [ipcf_pkg::CNT_W-1:0]  w_cnt_a;
    logic                        w_end_a;
    logic [15:0]                 w_crc_cur;
    logic [15:0]                 w_crc_nx;
    logic [3*ipcf_pkg::FRAME_BITS-1:0] w_bits;
    logic [ipcf_pkg::BUF_W-1:0]  w_ins;

    localparam logic [ipcf_pkg::CNT_W-1:0] CntByte = ipcf_pkg::CNT_W'(8);

    assign w_full    = (r_cnt >= CntByte);
    assign o_pop_vld = w_full || (r_end && (r_cnt != '0));
    assign w_pop     = o_pop_vld && i_pop_rdy;

    // bits above r_cnt are always zero, so the low byte is the output
    assign o_item.out_byte   = r_buf[7:0];
    assign o_item.valid_bits = w_full ? 4'd8 : r_cnt[3:0];
    assign o_item.frame_end  = r_end && (r_cnt <= CntByte);

    always_comb begin
        w_buf_a = w_pop ? (r_buf >> 8) : r_buf;
        w_cnt_a = r_cnt;
        w_end_a = r_end;
        if (w_pop) begin
            w_cnt_a = w_full ? (r_cnt - CntByte) : '0;
            if (r_cnt <= CntByte) begin
                w_end_a = 1'b0;
            end
        end
    end

    assign w_take     = r_in_vld && (w_cnt_a < CntByte) && !w_end_a;
    assign i_in.ready = !r_in_vld || w_take;

    assign w_crc_cur = r_in_frame ? r_crc : i_crc_seed;
    assign w_crc_nx  = ipcf_pkg::crc_a_byte(w_crc_cur, r_in_byte);

    always_comb begin
        if (r_in_last) begin
            w_bits = {ipcf_pkg::with_parity(w_crc_nx[15:8]),
                      ipcf_pkg::with_parity(w_crc_nx[7:0]),
                      ipcf_pkg::with_parity(r_in_byte)};
        end else begin
            w_bits = {{(2*ipcf_pkg::FRAME_BITS){1'b0}},
                      ipcf_pkg::with_parity(r_in_byte)};
        end
        w_ins = {{(ipcf_pkg::BUF_W-3*ipcf_pkg::FRAME_BITS){1'b0}}, w_bits}
                << w_cnt_a[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
            r_end      <= 1'b0;
            r_buf      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_take) begin
                r_in_frame <= !r_in_last;
                r_buf      <= w_buf_a | w_ins;
                r_cnt      <= w_cnt_a + (r_in_last ? ipcf_pkg::CNT_W'(27)
                                                   : ipcf_pkg::CNT_W'(9));
                r_end      <= r_in_last;
            end else begin
                r_buf <= w_buf_a;
                r_cnt <= w_cnt_a;
                r_end <= w_end_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (w_take) begin
            r_crc <= w_crc_nx;
        end
    end

    // Within a frame the buffer never holds more than one byte plus 8 bits
    a_cnt_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_end |-> (r_cnt <= ipcf_pkg::CNT_W'(16)))
        else $error("bit buffer overfilled mid-frame");

    // An end mark always has bits left to flush
    a_end_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end |-> (r_cnt != '0))
        else $error("frame end pending with empty buffer");

    // A last byte appends the trailer: the buffer holds at least 27 bits
    a_last_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_in_last) |=> (r_end && r_cnt >= ipcf_pkg::CNT_W'(27)))
        else $error("CRC trailer not appended");

endmodule

>>> rtl/ipcf_out_reg.sv
// ----------------------------------------------------------------------------
// ipcf_out_reg - output register of the framer
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ipcf_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  ipcf_pkg::t_out_item  i_item,
    output logic                 o_rdy,
    ipcf_out_if.source           o_out
);

    logic                r_vld;
    ipcf_pkg::t_out_item r_item;

    assign o_rdy = !r_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= i_item;
        end
    end

    assign o_out.valid      = r_vld;
    assign o_out.out_byte   = r_item.out_byte;
    assign o_out.valid_bits = r_item.valid_bits;
    assign o_out.frame_end  = r_item.frame_end;

endmodule

>>> test/tb_iso14443a_parity_crc_framer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso14443a_parity_crc_framer - self-checking bench for the 14443-A framer
// Feeds payload bytes in frames of random length under random valid/ready
// pressure. Expected output bytes come from a CRC_A and bit-packing predictor
// of its own or, for some directed steps, by hand, and are checked in order
// against the output channel. Seed writes fall between and inside frames.
// ----------------------------------------------------------------------------
module tb_iso14443a_parity_crc_framer;

    localparam logic [15:0] CRC_A_POLY    = 16'h8408;
    localparam logic [15:0] SEED_AT_RESET = 16'h6363;
    localparam int          RANDOM_ITEMS  = 136;
    localparam int          IDLE_PCT      = 18;
    localparam int          CYCLE_LIMIT   = 100000;

    // Directed steps: either a payload byte or a seed register write
    typedef enum logic {STEP_BYTE, STEP_SEED} t_step_kind;

    typedef struct packed {
        t_step_kind                     kind;
        logic [15:0]                    value;     // payload byte in [7:0], or the seed
        logic                           last;
        logic [2:0]                     n_typed;   // hand-written results, 0 = use predictor
        ipcf_pkg::t_out_item [4:0]      typed;
    } t_dir_step;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    ipcf_in_if  in_ch ();
    ipcf_out_if out_ch ();

    iso14443a_parity_crc_framer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: seed register, running CRC and the bit buffer
    // ------------------------------------------------------------------
    logic [15:0] seed_q;
    logic [15:0] crc_q;
    logic [15:0] acc_q;
    logic [2:0]  cnt_q;
    logic        in_frame_q;

    // Output bytes produced by the latest accepted payload byte
    ipcf_pkg::t_out_item   predicted [5];
    int                    predicted_n;

    // Output bytes still owed by the block, oldest first
    ipcf_pkg::t_out_item   framed_bytes_due [$];
    t_dir_step             directed_steps [$];

    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    bit                    calm           = 1'b0;   // suppresses all idling on both sides
    ipcf_pkg::t_out_item   got;
    ipcf_pkg::t_out_item   want;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bit-serial CRC_A: feedback bit is the CRC LSB xor the next data bit
    function automatic logic [15:0] crc_a_update(input logic [15:0] c,
                                                 input logic [7:0]  b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_A_POLY;
        end
        return r;
    endfunction

    // Append one byte and its odd parity bit; emit every full output byte
    function automatic void pack_nine(input logic [7:0] b);
        logic [31:0] bits;
        int          fill;
        bits = {23'd0, ($countones(b) % 2 == 0), b};
        bits = (bits << cnt_q) | {16'd0, acc_q};
        fill = cnt_q + 9;
        while (fill >= 8) begin
            predicted[predicted_n] = '{bits[7:0], 4'd8, 1'b0};
            predicted_n++;
            bits = bits >> 8;
            fill = fill - 8;
        end
        acc_q = bits[15:0];
        cnt_q = fill[2:0];
    endfunction

    // Full prediction for one payload byte, trailer and flush included
    function automatic void frame_payload_byte(input logic [7:0] b, input logic last);
        logic [15:0] chk;
        logic [7:0]  mask;
        predicted_n = 0;
        // CRC is loaded from the seed on the first byte of every frame, so a
        // seed written mid-frame only takes effect on the next frame
        if (!in_frame_q) begin
            crc_q      = seed_q;
            acc_q      = '0;
            cnt_q      = '0;
            in_frame_q = 1'b1;
        end
        crc_q = crc_a_update(crc_q, b);
        pack_nine(b);
        if (last) begin
            chk = crc_q;
            pack_nine(chk[7:0]);
            pack_nine(chk[15:8]);
            if (cnt_q != 3'd0) begin
                // leftover bits go out as a short final byte
                mask = (8'd1 << cnt_q) - 8'd1;
                predicted[predicted_n] = '{acc_q[7:0] & mask, {1'b0, cnt_q}, 1'b1};
                predicted_n++;
            end else begin
                // frame ended on a byte boundary: tag the last full byte
                predicted[predicted_n-1].frame_end = 1'b1;
            end
            acc_q      = '0;
            cnt_q      = '0;
            crc_q      = seed_q;
            in_frame_q = 1'b0;
        end
    endfunction

    function automatic ipcf_pkg::t_out_item out_rec(input logic [7:0] b,
                                                    input logic [3:0] n,
                                                    input logic e);
        return '{b, n, e};
    endfunction

    function automatic void add_step(input t_step_kind k, input logic [15:0] v,
                                     input logic l, input logic [2:0] n = 3'd0,
                                     input ipcf_pkg::t_out_item [4:0] t = '0);
        directed_steps.push_back('{k, v, l, n, t});
    endfunction

    function automatic logic [15:0] pick_seed();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return SEED_AT_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver. Valid stays high after a transaction so back-to-back
    // bytes never lower and raise it in one time step; a gap lowers it.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic last,
                             input logic [2:0] n_typed = 3'd0,
                             input ipcf_pkg::t_out_item [4:0] typed = '0);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        frame_payload_byte(b, last);
        if (n_typed != 3'd0) begin
            for (int k = 0; k < n_typed; k++)
                framed_bytes_due.push_back(typed[k]);
        end else begin
            for (int k = 0; k < predicted_n; k++)
                framed_bytes_due.push_back(predicted[k]);
        end
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Seed writes only once the output side has drained, plus a margin for the
    // input register, bit buffer and output register
    task automatic write_seed(input logic [15:0] s);
        in_ch.valid <= 1'b0;
        while (framed_bytes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_q    = s;
    endtask

    // ------------------------------------------------------------------
    // Output backpressure
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Output checker: every transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_byte, out_ch.valid_bits, out_ch.frame_end};
            if (framed_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output: byte %h bits %0d end %b",
                             got.out_byte, got.valid_bits, got.frame_end);
            end else begin
                want = framed_bytes_due.pop_front();
                if (got.out_byte !== want.out_byte || got.valid_bits !== want.valid_bits
                        || got.frame_end !== want.frame_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.out_byte, want.valid_bits, want.frame_end,
                                 got.out_byte, got.valid_bits, got.frame_end);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("iso14443a_parity_crc_framer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int         random_sent;
        int         frame_len;
        logic [7:0] b;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;

        seed_q     = SEED_AT_RESET;
        crc_q      = SEED_AT_RESET;
        acc_q      = '0;
        cnt_q      = '0;
        in_frame_q = 1'b0;

        // Zero byte right after reset: 8 zero data bits out, parity bit pending
        add_step(STEP_BYTE, 16'h0000, 1'b0, 3'd1,
                 {52'd0, out_rec(8'h00, 4'd8, 1'b0)});
        add_step(STEP_BYTE, 16'h00FF, 1'b1);
        // Zero seed and a zero single-byte frame: CRC stays zero, so the
        // stream is three parity-only 9-bit groups
        add_step(STEP_SEED, 16'h0000, 1'b0);
        add_step(STEP_BYTE, 16'h0000, 1'b1, 3'd4,
                 {13'd0, out_rec(8'h04, 4'd3, 1'b1), out_rec(8'h02, 4'd8, 1'b0),
                  out_rec(8'h01, 4'd8, 1'b0), out_rec(8'h00, 4'd8, 1'b0)});
        // Six payload bytes plus CRC = 72 bits, ends on a byte boundary
        add_step(STEP_SEED, 16'hFFFF, 1'b0);
        add_step(STEP_BYTE, 16'h0001, 1'b0);
        add_step(STEP_BYTE, 16'h0080, 1'b0);
        add_step(STEP_BYTE, 16'h0055, 1'b0);
        add_step(STEP_BYTE, 16'h00AA, 1'b0);
        add_step(STEP_BYTE, 16'h007F, 1'b0);
        add_step(STEP_BYTE, 16'h00FE, 1'b1);
        // Seed rewritten mid-frame: old seed stays for this frame
        add_step(STEP_BYTE, 16'h0012, 1'b0);
        add_step(STEP_SEED, SEED_AT_RESET, 1'b0);
        add_step(STEP_BYTE, 16'h0034, 1'b1);
        add_step(STEP_BYTE, 16'h0093, 1'b1);
        add_step(STEP_SEED, 16'h1234, 1'b0);
        add_step(STEP_BYTE, 16'h0026, 1'b1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_SEED)
                write_seed(directed_steps[i].value);
            else
                send_item(directed_steps[i].value[7:0], directed_steps[i].last,
                          directed_steps[i].n_typed, directed_steps[i].typed);
        end

        // Random frames; a share are 14 bytes long to land on byte boundaries
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(5) == 0)
                write_seed(pick_seed());
            frame_len = ($urandom_range(7) == 0) ? 14 : $urandom_range(1, 8);
            if (frame_len > RANDOM_ITEMS - random_sent)
                frame_len = RANDOM_ITEMS - random_sent;
            for (int i = 0; i < frame_len; i++) begin
                calm = (random_sent >= 60 && random_sent < 100);
                if (i > 0 && $urandom_range(24) == 0)
                    write_seed(pick_seed());
                case ($urandom_range(9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                send_item(b, i == frame_len - 1);
                random_sent++;
            end
        end
        calm = 1'b0;

        // Drain, then keep clocking to catch stray output bytes
        in_ch.valid <= 1'b0;
        while (framed_bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("iso14443a_parity_crc_framer verification clean");
        else
            $display("iso14443a_parity_crc_framer verification failed");
        $finish;
    end

endmodule

>>> iso14443a_parity_crc_framer.f
rtl/ipcf_pkg.sv
rtl/ipcf_if.sv
rtl/ipcf_packer.sv
rtl/ipcf_out_reg.sv
rtl/iso14443a_parity_crc_framer.sv
test/tb_iso14443a_parity_crc_framer.sv
